// ----- rtl/core/cthr_pkg.sv -----
// Shared types, constants and register indexes of the cruise throttle controller.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps

package cthr_pkg;

   localparam int COUNTER_BITS_DEF = 16;
   localparam int ADC_BITS_DEF     = 12;

   localparam int RPM_BITS   = 14;
   localparam int SPEED_BITS = 8;
   localparam int DZ_BITS    = 12;
   localparam int STEP_BITS  = 8;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 14;

   // one detent is four counts
   localparam int STEP_SHIFT  = 2;
   localparam int STEP_COUNTS = 1 << STEP_SHIFT;

   localparam logic [SPEED_BITS-1:0] MIN_SPEED_RST    = 8'd30;
   localparam logic [SPEED_BITS-1:0] MAX_SPEED_RST    = 8'd130;
   localparam logic [RPM_BITS-1:0]   SHUTDOWN_RPM_RST = 14'd3500;
   localparam logic [DZ_BITS-1:0]    DEAD_ZONE_RST    = 12'd30;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MIN_SPEED    = 2'd0,
      CSR_MAX_SPEED    = 2'd1,
      CSR_SHUTDOWN_RPM = 2'd2,
      CSR_DEAD_ZONE    = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_INC  = 2'd1,
      DIR_DEC  = 2'd2
   } dir_type;

   typedef struct packed {
      logic [SPEED_BITS-1:0] min_speed;
      logic [SPEED_BITS-1:0] max_speed;
      logic [RPM_BITS-1:0]   shutdown_rpm;
      logic [DZ_BITS-1:0]    dead_zone;
   } cfg_type;

   typedef struct packed {
      logic                  pulse;
      logic [SPEED_BITS-1:0] latched_speed;
      logic                  hold_mode;
      logic                  active;
      dir_type               direction;
      logic                  motor_on;
      logic                  clutch_on;
   } ctrl_out_type;

endpackage

// ----- rtl/core/cthr_encoder.sv -----
// Quadrature encoder detent counter: stored reading and signed step output.
// Depends on cthr_pkg.
`timescale 1ns / 1ps

module cthr_encoder #(
   parameter int COUNTER_BITS = cthr_pkg::COUNTER_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic [COUNTER_BITS-1:0]        reading,
   output logic [cthr_pkg::STEP_BITS-1:0] steps
);

   localparam int DW = (COUNTER_BITS + 1 > cthr_pkg::STEP_BITS + 2) ?
                       COUNTER_BITS + 1 : cthr_pkg::STEP_BITS + 2;
   localparam logic signed [DW-1:0] STEP_POS = DW'(cthr_pkg::STEP_COUNTS);
   localparam logic signed [DW-1:0] STEP_NEG = -STEP_POS;
   localparam logic signed [DW-1:0] BIAS     = STEP_POS - DW'(1);

   logic [COUNTER_BITS-1:0] stored_ff, stored_in;
   logic signed [DW-1:0]    diff, rounded, quot;
   logic                    moved;

   always_comb begin
      diff    = $signed({{(DW-COUNTER_BITS){1'b0}}, reading})
              - $signed({{(DW-COUNTER_BITS){1'b0}}, stored_ff});
      moved   = (diff >= STEP_POS) || (diff <= STEP_NEG);
      // round toward zero for negative differences
      rounded = diff + (diff[DW-1] ? BIAS : '0);
      quot    = rounded >>> cthr_pkg::STEP_SHIFT;
      steps   = moved ? quot[cthr_pkg::STEP_BITS-1:0] : '0;
      stored_in = (advance && moved) ? reading : stored_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff <= '0;
      end else begin
         stored_ff <= stored_in;
      end
   end

endmodule

// ----- rtl/core/cthr_control.sv -----
// Engagement, mode and throttle motor control state for one tick per item.
// Depends on cthr_pkg.
`timescale 1ns / 1ps

module cthr_control #(
   parameter int ADC_BITS = cthr_pkg::ADC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            short_press,
   input  logic                            long_press,
   input  logic [cthr_pkg::RPM_BITS-1:0]   engine_rpm,
   input  logic [cthr_pkg::SPEED_BITS-1:0] vehicle_speed,
   input  logic [ADC_BITS-1:0]             accel_position,
   input  cthr_pkg::cfg_type               cfg,
   output cthr_pkg::ctrl_out_type          result
);

   localparam int EW = (ADC_BITS > cthr_pkg::DZ_BITS) ? ADC_BITS : cthr_pkg::DZ_BITS;

   logic                            engaged_ff, engaged_in;
   logic                            last_ff, last_in;
   logic                            mode_ff, mode_in;
   logic [cthr_pkg::SPEED_BITS-1:0] hold_ff, hold_in;
   logic [ADC_BITS-1:0]             target_ff, target_in;
   logic                            clutch_ff, clutch_in;
   logic                            motor_ff, motor_in;
   cthr_pkg::dir_type               dir_ff, dir_in;
   logic                            pulse;
   logic signed [ADC_BITS:0]        err;
   logic [ADC_BITS:0]               mag;
   logic [EW-1:0]                   mag_ext;

   always_comb begin
      mode_in   = long_press ? !mode_ff : mode_ff;
      engaged_in = engaged_ff;
      last_in   = last_ff;
      hold_in   = hold_ff;
      target_in = target_ff;
      clutch_in = clutch_ff;
      motor_in  = motor_ff;
      dir_in    = dir_ff;
      pulse     = 1'b0;

      err     = $signed({1'b0, target_ff}) - $signed({1'b0, accel_position});
      mag     = err[ADC_BITS] ? -err : err;
      mag_ext = EW'(mag[ADC_BITS-1:0]);

      if (!long_press && short_press) begin
         if (engaged_ff) begin
            engaged_in = 1'b0;
         end else if ((vehicle_speed > cfg.min_speed) && (vehicle_speed < cfg.max_speed)) begin
            hold_in    = vehicle_speed;
            engaged_in = 1'b1;
            clutch_in  = 1'b1;
         end
      end

      if (engine_rpm > cfg.shutdown_rpm) begin
         engaged_in = 1'b0;
      end

      if (engaged_in) begin
         if (!last_ff) begin
            clutch_in = 1'b1;
            motor_in  = 1'b1;
            pulse     = 1'b1;
            last_in   = 1'b1;
            target_in = accel_position;
         end else begin
            dir_in   = err[ADC_BITS] ? cthr_pkg::DIR_DEC : cthr_pkg::DIR_INC;
            motor_in = !(mag_ext < EW'(cfg.dead_zone));
         end
      end else begin
         clutch_in = 1'b0;
         motor_in  = 1'b0;
         dir_in    = cthr_pkg::DIR_NONE;
         last_in   = 1'b0;
      end

      result.pulse         = pulse;
      result.latched_speed = hold_in;
      result.hold_mode     = mode_in;
      result.active        = engaged_in;
      result.direction     = dir_in;
      result.motor_on      = motor_in;
      result.clutch_on     = clutch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         engaged_ff <= 1'b0;
         last_ff    <= 1'b0;
         mode_ff    <= 1'b0;
         hold_ff    <= '0;
         target_ff  <= '0;
         clutch_ff  <= 1'b0;
         motor_ff   <= 1'b0;
         dir_ff     <= cthr_pkg::DIR_NONE;
      end else if (advance) begin
         engaged_ff <= engaged_in;
         last_ff    <= last_in;
         mode_ff    <= mode_in;
         hold_ff    <= hold_in;
         target_ff  <= target_in;
         clutch_ff  <= clutch_in;
         motor_ff   <= motor_in;
         dir_ff     <= dir_in;
      end
   end

endmodule

// ----- rtl/core/cruise_throttle_controller_core.sv -----
// Cruise throttle controller top level: input register, tick logic, result register.
// Depends on cthr_pkg, cthr_encoder and cthr_control.
//
// Usage:
//   req_* carries one control tick per item; rsp_* returns exactly one result
//   item per tick, in order. csr_we/csr_addr/csr_wdata write the four limit
//   registers (min speed, max speed, shutdown rpm, dead zone);
//   write them only while no tick is in flight.
//   Two register stages: input register, then result register.
//   Throughput: one item per cycle unless the receiver stalls; the tick logic
//   is a single pass of compares and adds between the two registers.
//   Reset (synchronous, active high) empties both stages, clears all control
//   state and the stored encoder readings, and loads the register defaults.
//   When the receiver stalls, the result register holds its item and the
//   input register can still take one more tick; req_tready drops only
//   when both stages are full and rsp_tready is low.
`timescale 1ns / 1ps

module cruise_throttle_controller_core #(
   parameter int ADC_BITS     = cthr_pkg::ADC_BITS_DEF,
   parameter int COUNTER_BITS = cthr_pkg::COUNTER_BITS_DEF,
   localparam int REQ_RAW     = 2 * COUNTER_BITS + 2 + cthr_pkg::RPM_BITS
                              + cthr_pkg::SPEED_BITS + ADC_BITS,
   localparam int REQ_W       = ((REQ_RAW + 7) / 8) * 8,
   localparam int RSP_RAW     = 2 * cthr_pkg::STEP_BITS + 6 + cthr_pkg::SPEED_BITS + 1,
   localparam int RSP_W       = ((RSP_RAW + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // menu_encoder_count, cruise_encoder_count, short_press, long_press,
   // engine_rpm, vehicle_speed, accel_position, zero fill
   input  logic [REQ_W-1:0]                   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // menu_steps, cruise_steps, clutch_on, motor_on, motor_direction,
   // cruise_active, hold_mode, latched_speed, show_cruise_screen, zero fill
   output logic [RSP_W-1:0]                   rsp_tdata,
   input  logic                               csr_we,
   input  logic [cthr_pkg::CSR_IDX_BITS-1:0]  csr_addr,
   input  logic [cthr_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int O_CRUISE = COUNTER_BITS;
   localparam int O_SP     = 2 * COUNTER_BITS;
   localparam int O_LP     = O_SP + 1;
   localparam int O_RPM    = O_LP + 1;
   localparam int O_SPEED  = O_RPM + cthr_pkg::RPM_BITS;
   localparam int O_POS    = O_SPEED + cthr_pkg::SPEED_BITS;

   logic                            s1_valid_ff, s1_valid_in;
   logic [REQ_W-1:0]                s1_data_ff;
   logic                            out_valid_ff, out_valid_in;
   logic [cthr_pkg::STEP_BITS-1:0]  msteps_ff, csteps_ff;
   cthr_pkg::ctrl_out_type          ctrl_ff;
   logic [cthr_pkg::STEP_BITS-1:0]  msteps, csteps;
   cthr_pkg::ctrl_out_type          ctrl;
   cthr_pkg::cfg_type               cfg_ff, cfg_in;
   logic                            advance;
   logic                            req_take;

   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (cthr_pkg::csr_idx_type'(csr_addr))
            cthr_pkg::CSR_MIN_SPEED: begin
               cfg_in.min_speed = csr_wdata[cthr_pkg::SPEED_BITS-1:0];
            end
            cthr_pkg::CSR_MAX_SPEED: begin
               cfg_in.max_speed = csr_wdata[cthr_pkg::SPEED_BITS-1:0];
            end
            cthr_pkg::CSR_SHUTDOWN_RPM: begin
               cfg_in.shutdown_rpm = csr_wdata[cthr_pkg::RPM_BITS-1:0];
            end
            cthr_pkg::CSR_DEAD_ZONE: begin
               cfg_in.dead_zone = csr_wdata[cthr_pkg::DZ_BITS-1:0];
            end
         endcase
      end
   end

   cthr_encoder #(.COUNTER_BITS(COUNTER_BITS)) u_menu_enc (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .reading (s1_data_ff[COUNTER_BITS-1:0]),
      .steps   (msteps)
   );

   cthr_encoder #(.COUNTER_BITS(COUNTER_BITS)) u_cruise_enc (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .reading (s1_data_ff[O_CRUISE +: COUNTER_BITS]),
      .steps   (csteps)
   );

   cthr_control #(.ADC_BITS(ADC_BITS)) u_control (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .short_press    (s1_data_ff[O_SP]),
      .long_press     (s1_data_ff[O_LP]),
      .engine_rpm     (s1_data_ff[O_RPM +: cthr_pkg::RPM_BITS]),
      .vehicle_speed  (s1_data_ff[O_SPEED +: cthr_pkg::SPEED_BITS]),
      .accel_position (s1_data_ff[O_POS +: ADC_BITS]),
      .cfg            (cfg_ff),
      .result         (ctrl)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         cfg_ff.min_speed    <= cthr_pkg::MIN_SPEED_RST;
         cfg_ff.max_speed    <= cthr_pkg::MAX_SPEED_RST;
         cfg_ff.shutdown_rpm <= cthr_pkg::SHUTDOWN_RPM_RST;
         cfg_ff.dead_zone    <= cthr_pkg::DEAD_ZONE_RST;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_tdata;
      end
      if (advance) begin
         msteps_ff <= msteps;
         csteps_ff <= csteps;
         ctrl_ff   <= ctrl;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_W-RSP_RAW){1'b0}},
                        ctrl_ff.pulse, ctrl_ff.latched_speed, ctrl_ff.hold_mode,
                        ctrl_ff.active, ctrl_ff.direction, ctrl_ff.motor_on,
                        ctrl_ff.clutch_on, csteps_ff, msteps_ff};

`ifndef ASSERT_OFF
   a_pulse_engaged: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && ctrl_ff.pulse) |->
         (ctrl_ff.active && ctrl_ff.clutch_on && ctrl_ff.motor_on))
      else $error("screen pulse without full engagement");

   a_idle_outputs: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !ctrl_ff.active) |->
         (!ctrl_ff.clutch_on && !ctrl_ff.motor_on &&
          ctrl_ff.direction == cthr_pkg::DIR_NONE))
      else $error("actuator driven while cruise is off");

   a_motor_clutch: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && ctrl_ff.motor_on) |-> ctrl_ff.clutch_on)
      else $error("motor on with clutch open");

   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced item did not reach the result register");
`endif

endmodule
